@@ design/msad_pkg.sv @@
`timescale 1ns / 1ps

package msad_pkg;

   localparam int ACC_W = 33;

   localparam logic [1:0] STATUS_SAMPLE    = 2'd0;
   localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
   localparam logic [1:0] STATUS_SHORT_HDR = 2'd2;

   localparam logic [7:0] CSR_CHANNELS = 8'd0;
   localparam logic [7:0] CSR_BLK_LEN  = 8'd1;

   localparam logic [1:0] KIND_STEP  = 2'd0;
   localparam logic [1:0] KIND_NEWER = 2'd1;

   localparam logic [3:0] HDR_LAST_MONO   = 4'd6;
   localparam logic [3:0] HDR_LAST_STEREO = 4'd13;

   localparam logic [7:0] MAX_PRED_INDEX = 8'd6;

   localparam logic [22:0] STEP_MIN = 23'd16;
   localparam logic [22:0] STEP_MAX = 23'd2796202;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_ERR  = 8'b0000_0010,
      S_HDR  = 8'b0000_0100,
      S_MUL1 = 8'b0000_1000,
      S_MUL2 = 8'b0001_0000,
      S_MUL3 = 8'b0010_0000,
      S_MUL4 = 8'b0100_0000,
      S_STEP = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic                     load;
      logic signed [16:0]       mul_a;
      logic signed [22:0]       mul_b;
      logic signed [ACC_W-1:0]  addend;
   } mac_req_type;

   function automatic logic signed [10:0] coef_a(input logic [2:0] ix);
      logic signed [10:0] c;
      case (ix)
         3'd0:    c = 11'sd256;
         3'd1:    c = 11'sd512;
         3'd2:    c = 11'sd0;
         3'd3:    c = 11'sd192;
         3'd4:    c = 11'sd240;
         3'd5:    c = 11'sd460;
         3'd6:    c = 11'sd392;
         default: c = 11'sd256;
      endcase
      return c;
   endfunction

   function automatic logic signed [10:0] coef_b(input logic [2:0] ix);
      logic signed [10:0] c;
      case (ix)
         3'd0:    c = 11'sd0;
         3'd1:    c = -11'sd256;
         3'd2:    c = 11'sd0;
         3'd3:    c = 11'sd64;
         3'd4:    c = 11'sd0;
         3'd5:    c = -11'sd208;
         3'd6:    c = -11'sd232;
         default: c = 11'sd0;
      endcase
      return c;
   endfunction

   function automatic logic [9:0] adapt_factor(input logic [3:0] nib);
      logic [9:0] f;
      case (nib)
         4'd0, 4'd1, 4'd2, 4'd3: f = 10'd230;
         4'd4:    f = 10'd307;
         4'd5:    f = 10'd409;
         4'd6:    f = 10'd512;
         4'd7:    f = 10'd614;
         4'd8:    f = 10'd768;
         4'd9:    f = 10'd614;
         4'd10:   f = 10'd512;
         4'd11:   f = 10'd409;
         4'd12:   f = 10'd307;
         default: f = 10'd230;
      endcase
      return f;
   endfunction

endpackage

@@ design/msad_if.sv @@
`timescale 1ns / 1ps

interface msad_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_of_packet;

   modport source (output valid, output data_byte, output last_of_packet, input ready);
   modport sink   (input valid, input data_byte, input last_of_packet, output ready);
endinterface

interface msad_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               channel;
   logic               last;
   logic [1:0]         status;

   modport source (output valid, output sample, output channel, output last,
                   output status, input ready);
   modport sink   (input valid, input sample, input channel, input last,
                   input status, output ready);
endinterface

interface msad_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  reg_index;
   logic [15:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ design/msad_mac.sv @@
`timescale 1ns / 1ps

module msad_mac (
   input  logic                                  clock,
   input  msad_pkg::mac_req_type                 req,
   output logic signed [msad_pkg::ACC_W-1:0]     acc
);
   import msad_pkg::*;

   logic signed [16:0]      op_a;
   logic signed [22:0]      op_b;
   logic signed [39:0]      product;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;

   assign op_a    = req.mul_a;
   assign op_b    = req.mul_b;
   assign product = op_a * op_b;
   assign acc_in  = req.addend + signed'(product[ACC_W-1:0]);
   assign acc     = acc_ff;

   always_ff @(posedge clock) begin
      if (req.load) begin
         acc_ff <= acc_in;
      end
   end

endmodule

@@ design/ms_adpcm_block_decoder_top.sv @@
`timescale 1ns / 1ps
// channel  dir  handshake      payload
// req_ch   in   valid/ready    data_byte[7:0], last_of_packet
// rsp_ch   out  valid/ready    sample[15:0] signed, channel, last, status[1:0]
// csr_ch   in   valid/ready    reg_index[7:0] (0 channels, 1 block length), wr_data[15:0]
//
// Header bytes that produce nothing are only stored; the last header byte then issues 2 or 4 header samples.
// A data byte is accepted, then per nibble makes 4 passes through the
// shared multiply-accumulate unit and a step state that adapts the step and issues the item.
// Reset (synchronous) clears control state and sets config to defaults; sample state loads from the header.
// req ready is high only when idle; rsp backpressure holds the sequencer at its output cycles.

module ms_adpcm_block_decoder_top (
   input  logic        clock,
   input  logic        reset,
   msad_req_if.sink    req_ch,
   msad_rsp_if.source  rsp_ch,
   msad_csr_if.sink    csr_ch
);
   import msad_pkg::*;

   state_type state_ff, state_in;
   logic [15:0] pos_ff, pos_in;
   logic        skip_ff, skip_in;
   logic [1:0]  channels_ff;
   logic [15:0] blk_len_ff;

   logic [7:0]  byte_ff, byte_in;
   logic        end_ff, end_in;
   logic        nib_sel_ff, nib_sel_in;
   logic [1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [1:0]  err_status_ff, err_status_in;
   logic        err_chan_ff, err_chan_in;
   logic [7:0]  low_byte_ff, low_byte_in;
   logic signed [15:0] sample_ff, sample_in;

   logic [2:0]         pidx_ff  [2];
   logic [2:0]         pidx_in  [2];
   logic signed [22:0] step_ff  [2];
   logic signed [22:0] step_in  [2];
   logic signed [15:0] newer_ff [2];
   logic signed [15:0] newer_in [2];
   logic signed [15:0] older_ff [2];
   logic signed [15:0] older_in [2];

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_channel_ff, rsp_channel_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   mac_req_type             mac_req;
   logic signed [ACC_W-1:0] acc;

   logic        stereo, req_fire, out_free, blk_end;
   logic [15:0] pos_next;
   logic [3:0]  hdr_last;
   logic        in_header, is_index, bad_index, hdr_final_byte;
   logic [3:0]  hdr_off;
   logic [1:0]  hdr_kind;
   logic        hdr_ch;
   logic signed [15:0] hdr_raw;

   logic        emit_newer, emit_ch, emit_final;

   logic        nib_ch;
   logic [3:0]  nib;
   logic [2:0]  pidx_cur;
   logic signed [10:0] c1, c2;
   logic signed [22:0] step_cur;
   logic signed [ACC_W-1:0] acc_bias, trunc_q;
   logic signed [15:0] pred_clip;
   logic [23:0] acc_shr;
   logic [22:0] step_new;

   assign stereo   = channels_ff[1];
   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign pos_next = pos_ff + 16'd1;
   assign blk_end  = req_ch.last_of_packet || (pos_next == blk_len_ff);

   assign hdr_last       = stereo ? HDR_LAST_STEREO : HDR_LAST_MONO;
   assign in_header      = pos_ff <= {12'd0, hdr_last};
   assign is_index       = (pos_ff == 16'd0) || (stereo && pos_ff == 16'd1);
   assign bad_index      = in_header && is_index && (req_ch.data_byte > MAX_PRED_INDEX);
   assign hdr_final_byte = pos_ff[3:0] == hdr_last;
   assign hdr_off        = pos_ff[3:0] - (stereo ? 4'd2 : 4'd1);
   assign hdr_kind       = stereo ? hdr_off[3:2] : hdr_off[2:1];
   assign hdr_ch         = stereo ? hdr_off[1] : 1'b0;
   assign hdr_raw        = signed'({req_ch.data_byte, low_byte_ff});

   assign emit_newer = stereo ? hdr_cnt_ff[1] : hdr_cnt_ff[0];
   assign emit_ch    = stereo ? hdr_cnt_ff[0] : 1'b0;
   assign emit_final = hdr_cnt_ff == (stereo ? 2'd3 : 2'd1);

   assign nib_ch   = nib_sel_ff & stereo;
   assign nib      = nib_sel_ff ? byte_ff[3:0] : byte_ff[7:4];
   assign pidx_cur = pidx_ff[nib_ch];
   assign c1       = coef_a(pidx_cur);
   assign c2       = coef_b(pidx_cur);
   assign step_cur = step_ff[nib_ch];

   assign acc_bias = acc + (acc[ACC_W-1] ? 33'sd255 : 33'sd0);
   assign trunc_q  = acc_bias >>> 8;
   assign acc_shr  = acc[ACC_W-2:8];

   always_comb begin
      if (acc > 33'sd32767) begin
         pred_clip = 16'sd32767;
      end else if (acc < -33'sd32768) begin
         pred_clip = -16'sd32768;
      end else begin
         pred_clip = acc[15:0];
      end
   end

   always_comb begin
      if (step_cur[22] || step_cur == 23'sd0) begin
         step_new = STEP_MIN;
      end else if (acc_shr < {1'b0, STEP_MIN}) begin
         step_new = STEP_MIN;
      end else if (acc_shr > {1'b0, STEP_MAX}) begin
         step_new = STEP_MAX;
      end else begin
         step_new = acc_shr[22:0];
      end
   end

   always_comb begin
      mac_req = '0;
      case (state_ff)
         S_MUL1: begin
            mac_req.load   = 1'b1;
            mac_req.mul_a  = {newer_ff[nib_ch][15], newer_ff[nib_ch]};
            mac_req.mul_b  = {{12{c1[10]}}, c1};
         end
         S_MUL2: begin
            mac_req.load   = 1'b1;
            mac_req.mul_a  = {older_ff[nib_ch][15], older_ff[nib_ch]};
            mac_req.mul_b  = {{12{c2[10]}}, c2};
            mac_req.addend = acc;
         end
         S_MUL3: begin
            mac_req.load   = 1'b1;
            mac_req.mul_a  = {{13{nib[3]}}, nib};
            mac_req.mul_b  = step_cur;
            mac_req.addend = trunc_q;
         end
         S_MUL4: begin
            mac_req.load   = 1'b1;
            mac_req.mul_a  = {7'd0, adapt_factor(nib)};
            mac_req.mul_b  = step_cur;
         end
         default: begin
            mac_req = '0;
         end
      endcase
   end

   msad_mac u_mac (
      .clock (clock),
      .req   (mac_req),
      .acc   (acc)
   );

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      skip_in        = skip_ff;
      byte_in        = byte_ff;
      end_in         = end_ff;
      nib_sel_in     = nib_sel_ff;
      hdr_cnt_in     = hdr_cnt_ff;
      err_status_in  = err_status_ff;
      err_chan_in    = err_chan_ff;
      low_byte_in    = low_byte_ff;
      sample_in      = sample_ff;
      pidx_in        = pidx_ff;
      step_in        = step_ff;
      newer_in       = newer_ff;
      older_in       = older_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_sample_in  = rsp_sample_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               byte_in = req_ch.data_byte;
               end_in  = blk_end;
               if (blk_end) begin
                  pos_in  = '0;
                  skip_in = 1'b0;
               end else begin
                  pos_in  = pos_next;
                  skip_in = skip_ff | bad_index;
               end
               if (!skip_ff) begin
                  if (in_header) begin
                     if (is_index) begin
                        if (bad_index) begin
                           err_status_in = STATUS_BAD_INDEX;
                           err_chan_in   = pos_ff[0];
                           state_in      = S_ERR;
                        end else begin
                           pidx_in[pos_ff[0]] = req_ch.data_byte[2:0];
                        end
                     end else if (!hdr_off[0]) begin
                        low_byte_in = req_ch.data_byte;
                     end else begin
                        case (hdr_kind)
                           KIND_STEP:  step_in[hdr_ch]  = {{7{hdr_raw[15]}}, hdr_raw};
                           KIND_NEWER: newer_in[hdr_ch] = hdr_raw;
                           default:    older_in[hdr_ch] = hdr_raw;
                        endcase
                     end
                     if (!bad_index) begin
                        if (hdr_final_byte) begin
                           hdr_cnt_in = '0;
                           state_in   = S_HDR;
                        end else if (blk_end) begin
                           err_status_in = STATUS_SHORT_HDR;
                           err_chan_in   = 1'b0;
                           state_in      = S_ERR;
                        end
                     end
                  end else begin
                     nib_sel_in = 1'b0;
                     state_in   = S_MUL1;
                  end
               end
            end
         end
         S_ERR: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_sample_in  = '0;
               rsp_channel_in = err_chan_ff;
               rsp_last_in    = 1'b1;
               rsp_status_in  = err_status_ff;
               state_in       = S_IDLE;
            end
         end
         S_HDR: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_sample_in  = emit_newer ? newer_ff[emit_ch] : older_ff[emit_ch];
               rsp_channel_in = emit_ch;
               rsp_last_in    = emit_final && end_ff;
               rsp_status_in  = STATUS_SAMPLE;
               if (emit_final) begin
                  state_in = S_IDLE;
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 2'd1;
               end
            end
         end
         S_MUL1: begin
            state_in = S_MUL2;
         end
         S_MUL2: begin
            state_in = S_MUL3;
         end
         S_MUL3: begin
            state_in = S_MUL4;
         end
         S_MUL4: begin
            older_in[nib_ch] = newer_ff[nib_ch];
            newer_in[nib_ch] = pred_clip;
            sample_in        = pred_clip;
            state_in         = S_STEP;
         end
         S_STEP: begin
            if (out_free) begin
               step_in[nib_ch] = step_new;
               rsp_valid_in    = 1'b1;
               rsp_sample_in   = sample_ff;
               rsp_channel_in  = nib_ch;
               rsp_last_in     = nib_sel_ff && end_ff;
               rsp_status_in   = STATUS_SAMPLE;
               if (nib_sel_ff) begin
                  state_in = S_IDLE;
               end else begin
                  nib_sel_in = 1'b1;
                  state_in   = S_MUL1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ch.ready   = state_ff == S_IDLE;
   assign csr_ch.ready   = 1'b1;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.sample  = rsp_sample_ff;
   assign rsp_ch.channel = rsp_channel_ff;
   assign rsp_ch.last    = rsp_last_ff;
   assign rsp_ch.status  = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         channels_ff  <= 2'd1;
         blk_len_ff   <= 16'd1024;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.reg_index)
               CSR_CHANNELS: channels_ff <= csr_ch.wr_data[1:0];
               CSR_BLK_LEN:  blk_len_ff  <= csr_ch.wr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff        <= byte_in;
      end_ff         <= end_in;
      nib_sel_ff     <= nib_sel_in;
      hdr_cnt_ff     <= hdr_cnt_in;
      err_status_ff  <= err_status_in;
      err_chan_ff    <= err_chan_in;
      low_byte_ff    <= low_byte_in;
      sample_ff      <= sample_in;
      pidx_ff        <= pidx_in;
      step_ff        <= step_in;
      newer_ff       <= newer_in;
      older_ff       <= older_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_status_ff  <= rsp_status_in;
   end

`ifndef SYNTH
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_SAMPLE |-> rsp_last_ff && rsp_sample_ff == 16'sd0)
      else $error("error item without last or with nonzero sample");

   a_block_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && blk_end |=> pos_ff == 16'd0 && !skip_ff)
      else $error("block end did not clear position");

   a_skip_stays_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && skip_ff |=> state_ff == S_IDLE)
      else $error("skipped byte started work");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STEP && state_in != S_STEP |=>
         !step_ff[$past(nib_ch)][22] &&
         step_ff[$past(nib_ch)] >= signed'(STEP_MIN) &&
         step_ff[$past(nib_ch)] <= signed'(STEP_MAX))
      else $error("adapted step out of range");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ch.ready)
      else $error("input accepted while sequencer busy");
`endif

endmodule
